// ===== rtl/bpg_pkg.sv =====
`default_nettype none

package bpg_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned PERCENT_W = 7;
  localparam int unsigned AVG_W     = 12;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned CNT_W     = 8;

  // accumulator widths
  localparam int unsigned HSUM_W = 11;
  localparam int unsigned NSUM_W = 7;
  localparam int unsigned IDX_W  = 3;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_PERIOD   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAFETY_PERIOD = 1'd1;

  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 8'd30;
  localparam logic [PERIOD_W-1:0] SAFETY_PERIOD_RST = 8'd60;

  // voltage breakpoints
  localparam logic [AVG_W-1:0] V_EMPTY  = 12'd1450;
  localparam logic [AVG_W-1:0] V_SEG2   = 12'd1886;
  localparam logic [AVG_W-1:0] V_SEG3   = 12'd2020;
  localparam logic [AVG_W-1:0] V_SAFETY = 12'd2060;
  localparam logic [AVG_W-1:0] V_SEG4   = 12'd2100;
  localparam logic [AVG_W-1:0] V_FULL   = 12'd2118;

  localparam logic [PERCENT_W-1:0] LVL_FULL_TARGET = 7'd120;
  localparam logic [PERCENT_W-1:0] LVL_MAX         = 7'd100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                charging;
  } bpg_in_t;

  typedef struct packed {
    logic [PERCENT_W-1:0] percent;
    logic [AVG_W-1:0]     average;
    logic                 full_detected;
    logic                 power_off_request;
  } bpg_out_t;

  // level tracking state carried between measurements
  typedef struct packed {
    logic [PERCENT_W-1:0] level;
    logic [CNT_W-1:0]     slow_cnt;
    logic [CNT_W-1:0]     safety_cnt;
  } bpg_state_t;

endpackage

`default_nettype wire

// ===== rtl/bpg_level.sv =====
`default_nettype none

module bpg_level (
  input  wire logic [bpg_pkg::AVG_W-1:0]    avg,
  input  wire logic                         charging,
  input  wire logic [bpg_pkg::PERIOD_W-1:0] slow_period,
  input  wire logic [bpg_pkg::PERIOD_W-1:0] safety_period,
  input  wire bpg_pkg::bpg_state_t          st,
  output bpg_pkg::bpg_state_t               st_nxt,
  output logic                              full,
  output logic                              power_off
);
  import bpg_pkg::*;

  logic [AVG_W-1:0]     d1, d2, d3, d4;
  logic [PERCENT_W-1:0] target;
  logic [PERCENT_W-1:0] target_chg;
  logic                 chg_below;
  logic [PERCENT_W-1:0] lvl_bat;
  logic [CNT_W:0]       slow_inc, safety_inc;
  logic [CNT_W-1:0]     safety_base;
  logic                 slow_step, safety_step;
  logic                 slow_want;
  logic [PERCENT_W-1:0] lvl_raw;

  // piecewise-linear target map
  always_comb begin
    d1 = avg - V_EMPTY;
    d2 = avg - V_SEG2;
    d3 = avg - V_SEG3;
    d4 = avg - V_SEG4;
    if (avg > V_FULL) begin
      target = LVL_FULL_TARGET;
    end else if (avg >= V_SEG4) begin
      target = d4[PERCENT_W-1:0] + 7'd100;
    end else if (avg >= V_SEG3) begin
      target = d3[PERCENT_W:1] + 7'd60;
    end else if (avg >= V_SEG2) begin
      target = d2[PERCENT_W+1:2] + 7'd27;
    end else begin
      target = d1[PERCENT_W+3:4];
    end
  end

  // remap while charging; a target of exactly 15 underflows to "always below"
  always_comb begin
    if (target < 7'd15) begin
      target_chg = 7'd1;
    end else if (target < 7'd30) begin
      target_chg = target - 7'd16;
    end else if (target < 7'd40) begin
      target_chg = target - 7'd17;
    end else if (target < LVL_FULL_TARGET) begin
      target_chg = target - 7'd18;
    end else begin
      target_chg = target;
    end
    chg_below = (target == 7'd15) || (st.level < target_chg);
  end

  always_comb begin
    lvl_bat   = (st.level == '0) ? target : st.level;
    slow_want = charging ? chg_below : (lvl_bat > target);

    slow_inc  = {1'b0, st.slow_cnt} + 9'd1;
    slow_step = slow_want && (slow_inc > {1'b0, slow_period});

    safety_base = (charging && slow_step) ? '0 : st.safety_cnt;
    safety_inc  = {1'b0, safety_base} + 9'd1;
    safety_step = charging && (avg > V_SAFETY) && (safety_inc > {1'b0, safety_period});

    st_nxt    = st;
    full      = 1'b0;
    power_off = 1'b0;
    lvl_raw   = st.level;

    if (avg < V_EMPTY) begin
      lvl_raw   = '0;
      power_off = !charging;
    end else begin
      full = avg > V_FULL;
      if (slow_want) begin
        st_nxt.slow_cnt = slow_step ? '0 : slow_inc[CNT_W-1:0];
      end
      if (charging) begin
        if (avg > V_SAFETY) begin
          st_nxt.safety_cnt = safety_step ? '0 : safety_inc[CNT_W-1:0];
        end else begin
          st_nxt.safety_cnt = safety_base;
        end
        lvl_raw = st.level + {6'd0, slow_step} + {6'd0, safety_step};
      end else begin
        lvl_raw = lvl_bat - {6'd0, slow_step};
      end
    end
    st_nxt.level = (lvl_raw > LVL_MAX) ? LVL_MAX : lvl_raw;
  end

endmodule

`default_nettype wire

// ===== rtl/battery_percent_gauge.sv =====
`default_nettype none

// channel  | ports                         | moves
// ---------+-------------------------------+-------------------------------------
// input    | in_valid, in_ready, in_data   | one adc sample and charger flag
// result   | out_valid, out_ready, out_data| percent, average, full, power-off
// config   | cfg_we, cfg_addr, cfg_wdata   | slow / safety step periods
//
// one sample transfer per cycle while in_ready is high; every eighth sample closes a group
// the closing transfer loads the average register; once the result register is empty or being taken,
// the average moves on into the result register and out_valid rises
// rst_n is synchronous: sums, index, level, counters cleared, periods to 30 / 60
// while a finished group waits in the average register behind an untaken result,
// in_ready is low and no sample transfers, closing or not

module battery_percent_gauge (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bpg_pkg::bpg_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bpg_pkg::bpg_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [bpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bpg_pkg::PERIOD_W-1:0]   cfg_wdata
);
  import bpg_pkg::*;

  // configuration
  logic [PERIOD_W-1:0] slow_period_r, safety_period_r;

  // group accumulator
  logic [HSUM_W-1:0] hsum_r, hsum_nxt;
  logic [NSUM_W-1:0] nsum_r, nsum_nxt;
  logic [IDX_W-1:0]  idx_r;

  // average stage
  logic              avg_valid_r;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic              avg_chg_r;
  logic [HSUM_W+4:0] avg_sum;

  // level state and result register
  bpg_state_t st_r, st_nxt;
  logic       full, power_off;
  logic       out_valid_r;
  bpg_out_t   out_r;

  logic in_xfer, group_done, avg_adv;

  assign avg_adv    = avg_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !avg_valid_r || avg_adv;
  assign in_xfer    = in_valid && in_ready;
  assign group_done = (idx_r == IDX_W'(7));

  // running sums of high bytes and low nibbles
  assign hsum_nxt = hsum_r + {3'd0, in_data.sample[SAMPLE_W-1:4]};
  assign nsum_nxt = nsum_r + {3'd0, in_data.sample[3:0]};

  // average: high sum scaled back up, plus only the upper part of the nibble sum
  assign avg_sum = {1'b0, hsum_nxt, 4'd0} + {9'd0, nsum_nxt[NSUM_W-1:4], 4'd0};
  assign avg_nxt = avg_sum[AVG_W+2:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_period_r   <= SLOW_PERIOD_RST;
      safety_period_r <= SAFETY_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SLOW_PERIOD:   slow_period_r   <= cfg_wdata;
        CFG_SAFETY_PERIOD: safety_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsum_r <= '0;
      nsum_r <= '0;
      idx_r  <= '0;
    end else if (in_xfer) begin
      idx_r <= idx_r + IDX_W'(1);
      if (group_done) begin
        hsum_r <= '0;
        nsum_r <= '0;
      end else begin
        hsum_r <= hsum_nxt;
        nsum_r <= nsum_nxt;
      end
    end
  end

  // average register holds one finished group until the result side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_valid_r <= 1'b0;
    end else if (in_xfer && group_done) begin
      avg_valid_r <= 1'b1;
    end else if (avg_adv) begin
      avg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && group_done) begin
      avg_r     <= avg_nxt;
      avg_chg_r <= in_data.charging;
    end
  end

  bpg_level u_level (
    .avg           (avg_r),
    .charging      (avg_chg_r),
    .slow_period   (slow_period_r),
    .safety_period (safety_period_r),
    .st            (st_r),
    .st_nxt        (st_nxt),
    .full          (full),
    .power_off     (power_off)
  );

  // level state moves only when a measurement reaches the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (avg_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (avg_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_adv) begin
      out_r.percent           <= st_nxt.level;
      out_r.average           <= avg_r;
      out_r.full_detected     <= full;
      out_r.power_off_request <= power_off;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
